>>> rtl/mcve_pkg.sv
// Shared types and constants of the matrix column vector engine.
// Depends on nothing; the files that use it refer to it by scoped names.
package mcve_pkg;

    localparam int CMD_W      = 3;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int DATA_W     = 32;
    localparam int STS_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_SUB   = 3'd2,
        CMD_DOT   = 3'd3,
        CMD_NORM  = 3'd4
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_ZERO  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WR_ONE,
        S_RD_ONE,
        S_RD_CAP,
        S_RD_I,
        S_RD_J,
        S_CAPB,
        S_MUL,
        S_ACC,
        S_DOT_FIN,
        S_SQ_GO,
        S_SQ_WAIT,
        S_N_RD,
        S_N_CAP,
        S_N_DIV,
        S_DONE
    } t_state;

    typedef enum logic {
        UOP_SQRT,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

>>> rtl/mcve_if.sv
// Handshake channels of the engine: command, response and configuration.
// Depends on mcve_pkg for payload widths.
interface mcve_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [mcve_pkg::CMD_W-1:0]         command;
    logic [mcve_pkg::ROW_W-1:0]         row_index;
    logic [mcve_pkg::COL_W-1:0]         first_column;
    logic [mcve_pkg::COL_W-1:0]         second_column;
    logic signed [mcve_pkg::DATA_W-1:0] value;

    modport source (output valid, command, row_index, first_column, second_column, value,
                    input ready);
    modport sink   (input valid, command, row_index, first_column, second_column, value,
                    output ready);
endinterface

interface mcve_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [mcve_pkg::DATA_W-1:0] result_value;
    logic [mcve_pkg::STS_W-1:0]         status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

interface mcve_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mcve_pkg::CFG_IDX_W-1:0]     index;
    logic [mcve_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/mcve_ram.sv
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
module mcve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mcve_sqdiv.sv
// Iterative square root / restoring divider sharing one 64-bit compare-subtract.
// Depends on mcve_pkg (t_unit_ctl, t_unit_sts).
module mcve_sqdiv #(
    parameter int DW = 49
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mcve_pkg::t_unit_ctl  i_ctl,
    input  logic [63:0]          i_radicand,
    input  logic [DW-1:0]        i_dividend,
    input  logic [31:0]          i_divisor,
    output mcve_pkg::t_unit_sts  o_sts,
    output logic [31:0]          o_root,
    output logic [63:0]          o_rem,
    output logic [DW-1:0]        o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    mcve_pkg::t_unit_op r_op, n_op;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [63:0]        r_x, n_x;
    logic [63:0]        r_res, n_res;
    logic [63:0]        r_bit, n_bit;
    logic [DW-1:0]      r_q, n_q;
    logic [31:0]        r_d, n_d;

    logic [63:0] w_min, w_sub, w_diff;
    logic        w_ge;

    // shared compare-subtract
    always_comb begin
        if (r_op == mcve_pkg::UOP_SQRT) begin
            w_min = r_x;
            w_sub = r_res + r_bit;
        end else begin
            w_min = {r_x[62:0], r_q[DW-1]};
            w_sub = 64'(r_d);
        end
        w_ge   = (w_min >= w_sub);
        w_diff = w_min - w_sub;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_res  = r_res;
        n_bit  = r_bit;
        n_q    = r_q;
        n_d    = r_d;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_x    = (i_ctl.op == mcve_pkg::UOP_SQRT) ? i_radicand : 64'd0;
            n_res  = 64'd0;
            n_bit  = 64'd1 << 62;
            n_q    = i_dividend;
            n_d    = i_divisor;
            n_cnt  = (i_ctl.op == mcve_pkg::UOP_SQRT) ? CW'(31) : CW'(DW - 1);
        end else if (r_busy) begin
            if (r_op == mcve_pkg::UOP_SQRT) begin
                if (w_ge) begin
                    n_x   = w_diff;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
            end else begin
                n_x = w_ge ? w_diff : w_min;
                n_q = {r_q[DW-2:0], w_ge};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= mcve_pkg::UOP_SQRT;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_x   <= n_x;
        r_res <= n_res;
        r_bit <= n_bit;
        r_q   <= n_q;
        r_d   <= n_d;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_res[31:0];
    assign o_rem      = r_x;
    assign o_quot     = r_q;

endmodule

>>> rtl/matrix_column_vector_engine.sv
// Top level of the matrix column vector engine: sequencer, multiplier, accumulator.
// Depends on mcve_pkg, mcve_if, mcve_ram and mcve_sqdiv.
//
//  channel   dir  handshake            payload
//  i_cmd     in   valid/ready          command, row_index, first_column, second_column, value
//  o_rsp     out  valid/ready          result_value, status
//  i_cfg     in   valid/ready (ready=1) index, data
//
// Normalize runs the square root unit once, then the serial divider, whose quotient
// is DW = 33 + FRACTION_BITS bits wide, once for each row in use.
// Reset is synchronous, active low; it clears control state and the config registers.
// The store itself has no reset and no clearing pass.
// One command at a time; a new command transfers while the last response still waits,
// and a finished command holds in its done state until the response register frees up.
module matrix_column_vector_engine #(
    parameter int MAX_ROWS      = 16,
    parameter int MAX_COLUMNS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcve_cmd_if.sink   i_cmd,
    mcve_rsp_if.source o_rsp,
    mcve_cfg_if.sink   i_cfg
);

    localparam int DEPTH    = MAX_ROWS * MAX_COLUMNS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW       = 33 + FRACTION_BITS;
    localparam int ROWS_RST = (MAX_ROWS < 16) ? MAX_ROWS : 16;
    localparam int COLS_RST = (MAX_COLUMNS < 16) ? MAX_COLUMNS : 16;

    localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRACTION_BITS - 1);
    localparam logic signed [69:0] HALF70 = 70'sd1 <<< (FRACTION_BITS - 1);
    localparam logic signed [69:0] MAX70  = 70'sh7FFFFFFF;
    localparam logic signed [69:0] MIN70  = -70'sh80000000;
    localparam logic [63:0]        LIMIT  = 64'd1 << 62;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [AW-1:0] f_addr(input logic [4:0] row, input logic [3:0] col);
        f_addr = AW'(int'(row) * MAX_COLUMNS + int'(col));
    endfunction

    // {saturated, value}
    function automatic logic [32:0] f_sat(input logic signed [69:0] v);
        if (v > MAX70) begin
            f_sat = {1'b1, 32'h7FFF_FFFF};
        end else if (v < MIN70) begin
            f_sat = {1'b1, 32'h8000_0000};
        end else begin
            f_sat = {1'b0, v[31:0]};
        end
    endfunction

    function automatic logic [4:0] f_clamp(input logic [4:0] m, input int max);
        logic [4:0] t;
        t = (m == 5'd0) ? 5'd1 : m;
        if (int'(t) > max) begin
            t = 5'(max);
        end
        f_clamp = t;
    endfunction

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [4:0] r_rows, r_cols;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 5'(ROWS_RST);
            r_cols <= 5'(COLS_RST);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mcve_pkg::CFG_ROWS: r_rows <= f_clamp(i_cfg.data, MAX_ROWS);
                mcve_pkg::CFG_COLS: r_cols <= f_clamp(i_cfg.data, MAX_COLUMNS);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    mcve_pkg::t_state  r_state, n_state;
    mcve_pkg::t_cmd    r_cmd, n_cmd;
    logic [3:0]        r_row, n_row;
    logic [3:0]        r_ci, n_ci;
    logic [3:0]        r_cj, n_cj;
    logic signed [31:0] r_val, n_val;
    logic [4:0]        r_k, n_k;
    logic signed [31:0] r_a, n_a;
    logic signed [31:0] r_b, n_b;
    logic signed [63:0] r_p, n_p;
    logic signed [69:0] r_acc, n_acc;
    logic [31:0]       r_norm, n_norm;
    logic [31:0]       r_result, n_result;
    mcve_pkg::t_status r_status, n_status;
    logic              r_ov, n_ov;
    logic [31:0]       r_out_val, n_out_val;
    mcve_pkg::t_status r_out_sts, n_out_sts;

    // store
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata;

    mcve_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // square root / divider
    mcve_pkg::t_unit_ctl u_ctl;
    mcve_pkg::t_unit_sts u_sts;
    logic [31:0]         u_root;
    logic [63:0]         u_rem;
    logic [DW-1:0]       u_quot;
    logic [DW-1:0]       w_dividend;

    mcve_sqdiv #(.DW(DW)) u_sqdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (u_ctl),
        .i_radicand (r_acc[63:0]),
        .i_dividend (w_dividend),
        .i_divisor  (r_norm),
        .o_sts      (u_sts),
        .o_root     (u_root),
        .o_rem      (u_rem),
        .o_quot     (u_quot)
    );

    // ------------------------------------------------------------------
    // shared combinational pieces
    // ------------------------------------------------------------------
    logic               w_accept, w_range_err, w_last;
    mcve_pkg::t_cmd     w_cmd;
    logic signed [31:0] w_mx, w_my;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_q64;
    logic [32:0]        w_sub_sat, w_dot_sat;
    logic [63:0]        w_nsum;
    logic [32:0]        w_rnd;
    logic               w_nbig, w_nzero;
    logic [31:0]        w_nval;
    logic [31:0]        w_mag;
    logic [31:0]        w_divout;

    assign i_cmd.ready = (r_state == mcve_pkg::S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_cmd       = mcve_pkg::t_cmd'(i_cmd.command);
    assign w_last      = (5'(r_k + 5'd1) == r_rows);

    always_comb begin
        w_range_err = ({1'b0, i_cmd.first_column} >= r_cols);
        case (w_cmd)
            mcve_pkg::CMD_WRITE,
            mcve_pkg::CMD_READ: w_range_err = w_range_err ||
                                              ({1'b0, i_cmd.row_index} >= r_rows);
            mcve_pkg::CMD_SUB,
            mcve_pkg::CMD_DOT:  w_range_err = w_range_err ||
                                              ({1'b0, i_cmd.second_column} >= r_cols);
            mcve_pkg::CMD_NORM: ;
            default:            w_range_err = 1'b1;
        endcase
    end

    // one multiplier, registered into r_p
    always_comb begin
        case (r_cmd)
            mcve_pkg::CMD_SUB: begin
                w_mx = r_val;
                w_my = r_a;
            end
            mcve_pkg::CMD_DOT: begin
                w_mx = r_a;
                w_my = r_b;
            end
            default: begin
                w_mx = r_a;
                w_my = r_a;
            end
        endcase
    end
    assign w_prod = w_mx * w_my;

    // subtract: rounded product taken off the destination element
    assign w_q64     = (r_p + HALF64) >>> FRACTION_BITS;
    assign w_sub_sat = f_sat(70'(r_b) - 70'(w_q64));

    // inner product: round the exact sum once
    assign w_dot_sat = f_sat((r_acc + HALF70) >>> FRACTION_BITS);

    // sum of squares, clamped at 2^62
    assign w_nsum = {1'b0, r_acc[62:0]} + {1'b0, r_p[62:0]};

    // norm rounded to nearest from root and remainder
    assign w_rnd   = {1'b0, u_root} + ((u_rem > 64'(u_root)) ? 33'd1 : 33'd0);
    assign w_nbig  = r_acc[62] || w_rnd[32] || w_rnd[31];
    assign w_nval  = w_nbig ? 32'h7FFF_FFFF : w_rnd[31:0];
    assign w_nzero = !w_nbig && (w_rnd == 33'd0);

    // divider operand: |a| << F plus half the norm, for round to nearest
    assign w_mag      = w_rdata[31] ? (~w_rdata + 32'd1) : w_rdata;
    assign w_dividend = (DW'(w_mag) << FRACTION_BITS) + DW'(r_norm >> 1);

    // sign and clamp of the divided element
    always_comb begin
        if (!r_a[31]) begin
            w_divout = (u_quot > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : u_quot[31:0];
        end else begin
            w_divout = (u_quot > DW'(33'h8000_0000)) ? 32'h8000_0000
                                                     : (~u_quot[31:0] + 32'd1);
        end
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcve_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_range_err) begin
                        n_state = mcve_pkg::S_DONE;
                    end else begin
                        case (w_cmd)
                            mcve_pkg::CMD_WRITE: n_state = mcve_pkg::S_WR_ONE;
                            mcve_pkg::CMD_READ:  n_state = mcve_pkg::S_RD_ONE;
                            mcve_pkg::CMD_SUB:   n_state = (i_cmd.value == 32'sd0) ?
                                                           mcve_pkg::S_DONE :
                                                           mcve_pkg::S_RD_I;
                            default:             n_state = mcve_pkg::S_RD_I;
                        endcase
                    end
                end
            end
            mcve_pkg::S_WR_ONE:  n_state = mcve_pkg::S_DONE;
            mcve_pkg::S_RD_ONE:  n_state = mcve_pkg::S_RD_CAP;
            mcve_pkg::S_RD_CAP:  n_state = mcve_pkg::S_DONE;
            mcve_pkg::S_RD_I:    n_state = mcve_pkg::S_RD_J;
            mcve_pkg::S_RD_J:    n_state = mcve_pkg::S_CAPB;
            mcve_pkg::S_CAPB:    n_state = mcve_pkg::S_MUL;
            mcve_pkg::S_MUL:     n_state = mcve_pkg::S_ACC;
            mcve_pkg::S_ACC: begin
                if (!w_last) begin
                    n_state = mcve_pkg::S_RD_I;
                end else begin
                    case (r_cmd)
                        mcve_pkg::CMD_DOT:  n_state = mcve_pkg::S_DOT_FIN;
                        mcve_pkg::CMD_NORM: n_state = mcve_pkg::S_SQ_GO;
                        default:            n_state = mcve_pkg::S_DONE;
                    endcase
                end
            end
            mcve_pkg::S_DOT_FIN: n_state = mcve_pkg::S_DONE;
            mcve_pkg::S_SQ_GO:   n_state = mcve_pkg::S_SQ_WAIT;
            mcve_pkg::S_SQ_WAIT: begin
                if (u_sts.done) begin
                    n_state = w_nzero ? mcve_pkg::S_DONE : mcve_pkg::S_N_RD;
                end
            end
            mcve_pkg::S_N_RD:    n_state = mcve_pkg::S_N_CAP;
            mcve_pkg::S_N_CAP:   n_state = mcve_pkg::S_N_DIV;
            mcve_pkg::S_N_DIV: begin
                if (u_sts.done) begin
                    n_state = w_last ? mcve_pkg::S_DONE : mcve_pkg::S_N_RD;
                end
            end
            mcve_pkg::S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = mcve_pkg::S_IDLE;
                end
            end
            default:             n_state = mcve_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_cmd     = r_cmd;
        n_row     = r_row;
        n_ci      = r_ci;
        n_cj      = r_cj;
        n_val     = r_val;
        n_k       = r_k;
        n_a       = r_a;
        n_b       = r_b;
        n_p       = r_p;
        n_acc     = r_acc;
        n_norm    = r_norm;
        n_result  = r_result;
        n_status  = r_status;
        n_ov      = r_ov && !o_rsp.ready;
        n_out_val = r_out_val;
        n_out_sts = r_out_sts;
        w_we      = 1'b0;
        w_waddr   = f_addr(r_k, r_cj);
        w_wdata   = w_sub_sat[31:0];
        w_raddr   = f_addr(r_k, r_ci);
        u_ctl     = '{start: 1'b0, op: mcve_pkg::UOP_SQRT};

        case (r_state)
            mcve_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = w_cmd;
                    n_row    = i_cmd.row_index;
                    n_ci     = i_cmd.first_column;
                    n_cj     = (w_cmd == mcve_pkg::CMD_NORM) ? i_cmd.first_column
                                                             : i_cmd.second_column;
                    n_val    = i_cmd.value;
                    n_k      = 5'd0;
                    n_acc    = '0;
                    n_result = 32'd0;
                    n_status = w_range_err ? mcve_pkg::ST_RANGE : mcve_pkg::ST_OK;
                end
            end
            mcve_pkg::S_WR_ONE: begin
                w_we    = 1'b1;
                w_waddr = f_addr({1'b0, r_row}, r_ci);
                w_wdata = r_val;
            end
            mcve_pkg::S_RD_ONE: begin
                w_raddr = f_addr({1'b0, r_row}, r_ci);
            end
            mcve_pkg::S_RD_CAP: begin
                n_result = w_rdata;
            end
            mcve_pkg::S_RD_I: begin
                w_raddr = f_addr(r_k, r_ci);
            end
            mcve_pkg::S_RD_J: begin
                w_raddr = f_addr(r_k, r_cj);
                n_a     = w_rdata;
            end
            mcve_pkg::S_CAPB: begin
                n_b = w_rdata;
            end
            mcve_pkg::S_MUL: begin
                n_p = w_prod;
            end
            mcve_pkg::S_ACC: begin
                case (r_cmd)
                    mcve_pkg::CMD_SUB: begin
                        w_we = 1'b1;
                        if (w_sub_sat[32]) begin
                            n_status = mcve_pkg::ST_SAT;
                        end
                    end
                    mcve_pkg::CMD_DOT: begin
                        n_acc = r_acc + 70'(r_p);
                    end
                    default: begin
                        n_acc = $signed(70'((w_nsum > LIMIT) ? LIMIT : w_nsum));
                    end
                endcase
                n_k = w_last ? 5'd0 : 5'(r_k + 5'd1);
            end
            mcve_pkg::S_DOT_FIN: begin
                n_result = w_dot_sat[31:0];
                if (w_dot_sat[32]) begin
                    n_status = mcve_pkg::ST_SAT;
                end
            end
            mcve_pkg::S_SQ_GO: begin
                u_ctl = '{start: 1'b1, op: mcve_pkg::UOP_SQRT};
            end
            mcve_pkg::S_SQ_WAIT: begin
                if (u_sts.done) begin
                    n_norm = w_nval;
                    if (w_nzero) begin
                        n_status = mcve_pkg::ST_ZERO;
                    end else begin
                        n_result = w_nval;
                        if (w_nbig) begin
                            n_status = mcve_pkg::ST_SAT;
                        end
                    end
                end
            end
            mcve_pkg::S_N_RD: begin
                w_raddr = f_addr(r_k, r_ci);
            end
            mcve_pkg::S_N_CAP: begin
                n_a   = w_rdata;
                u_ctl = '{start: 1'b1, op: mcve_pkg::UOP_DIV};
            end
            mcve_pkg::S_N_DIV: begin
                if (u_sts.done) begin
                    w_we    = 1'b1;
                    w_waddr = f_addr(r_k, r_ci);
                    w_wdata = w_divout;
                    n_k     = w_last ? 5'd0 : 5'(r_k + 5'd1);
                end
            end
            mcve_pkg::S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov      = 1'b1;
                    n_out_val = r_result;
                    n_out_sts = r_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcve_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_cmd     <= n_cmd;
        r_row     <= n_row;
        r_ci      <= n_ci;
        r_cj      <= n_cj;
        r_val     <= n_val;
        r_k       <= n_k;
        r_a       <= n_a;
        r_b       <= n_b;
        r_p       <= n_p;
        r_acc     <= n_acc;
        r_norm    <= n_norm;
        r_result  <= n_result;
        r_status  <= n_status;
        r_out_val <= n_out_val;
        r_out_sts <= n_out_sts;
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.result_value = r_out_val;
    assign o_rsp.status       = r_out_sts;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_cmd.ready)
        else $error("command transfer while busy");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state) == mcve_pkg::S_DONE)
        else $error("response raised outside done state");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == mcve_pkg::ST_RANGE ||
                         o_rsp.status == mcve_pkg::ST_ZERO)) |-> o_rsp.result_value == 0)
        else $error("error response with nonzero result");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state != mcve_pkg::S_IDLE)
        else $error("store write while idle");

    a_unit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_sts.busy |-> (r_state == mcve_pkg::S_SQ_WAIT || r_state == mcve_pkg::S_N_DIV))
        else $error("root/divide unit busy outside a wait state");

    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows != 5'd0 && int'(r_rows) <= MAX_ROWS &&
        r_cols != 5'd0 && int'(r_cols) <= MAX_COLUMNS)
        else $error("size register out of range");

endmodule

>>> tb/sv/tb_matrix_column_vector_engine.sv
// Self-checking testbench of the matrix column vector engine.
// Depends on mcve_pkg, mcve_if and the engine RTL; predicts every response in-line.
`timescale 1ns / 1ps

module tb_matrix_column_vector_engine;

    localparam int NR = 16;
    localparam int NC = 16;
    localparam int FB = 16;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [mcve_pkg::CMD_W-1:0]         command;
        logic [mcve_pkg::ROW_W-1:0]         row_index;
        logic [mcve_pkg::COL_W-1:0]         first_column;
        logic [mcve_pkg::COL_W-1:0]         second_column;
        logic signed [mcve_pkg::DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [mcve_pkg::DATA_W-1:0] result_value;
        logic [mcve_pkg::STS_W-1:0]         status;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mcve_cmd_if cmd_ch ();
    mcve_rsp_if rsp_ch ();
    mcve_cfg_if cfg_ch ();

    matrix_column_vector_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: matrix copy, which entries were written, active sizes
    logic signed [31:0] mat [NR][NC];
    bit                 written [NR][NC];
    int unsigned        rows_act = 16;
    int unsigned        cols_act = 16;

    t_item pending_cmds [$];
    t_resp expected_rsps [$];
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    stall_go = 0;      // starts the long receiver stall
    bit    recv_hold = 0;     // receiver held off while set
    bit    cmd_fire = 0;      // command transfer at the last rising edge

    function automatic longint floor_q(longint v);
        return v >>> FB;      // arithmetic shift is floor
    endfunction

    function automatic logic signed [31:0] clamp32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res = 0;
        longint unsigned bt = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // compute the response of one command and update the matrix copy
    function automatic t_resp engine_predict(t_item it);
        t_resp rsp;
        bit sat = 0;
        longint p, q, whole;
        longint unsigned frac, acc, r, sq, mag, uq;
        longint a;
        int i = int'(it.first_column);
        int j = int'(it.second_column);
        rsp.result_value = '0;
        rsp.status = mcve_pkg::ST_OK;
        if (it.command > mcve_pkg::CMD_NORM || i >= cols_act ||
            ((it.command == mcve_pkg::CMD_SUB || it.command == mcve_pkg::CMD_DOT) &&
             j >= cols_act) ||
            (it.command <= mcve_pkg::CMD_READ && it.row_index >= rows_act)) begin
            rsp.status = mcve_pkg::ST_RANGE;
        end else begin
            case (it.command)
                mcve_pkg::CMD_WRITE: begin
                    mat[it.row_index][i] = it.value;
                    written[it.row_index][i] = 1;
                end
                mcve_pkg::CMD_READ: rsp.result_value = mat[it.row_index][i];
                mcve_pkg::CMD_SUB: begin
                    if (it.value != 0)
                        for (int k = 0; k < rows_act; k++) begin
                            p = longint'(it.value) * longint'(mat[k][i]);
                            q = floor_q(p + (64'sd1 <<< (FB - 1)));
                            mat[k][j] = clamp32(longint'(mat[k][j]) - q, sat);
                        end
                    if (sat) rsp.status = mcve_pkg::ST_SAT;
                end
                mcve_pkg::CMD_DOT: begin
                    whole = 0;
                    frac = 0;
                    for (int k = 0; k < rows_act; k++) begin
                        p = longint'(mat[k][i]) * longint'(mat[k][j]);
                        whole += floor_q(p);
                        frac += p & ((64'd1 << FB) - 1);
                    end
                    whole += longint'((frac + (64'd1 << (FB - 1))) >> FB);
                    rsp.result_value = clamp32(whole, sat);
                    if (sat) rsp.status = mcve_pkg::ST_SAT;
                end
                default: begin
                    acc = 0;
                    for (int k = 0; k < rows_act; k++) begin
                        a = mat[k][i];
                        sq = a * a;
                        acc = (sq > (64'd1 << 62) - acc) ? (64'd1 << 62) : acc + sq;
                    end
                    if (acc >= (64'd1 << 62)) begin
                        r = 64'd2147483648;
                    end else begin
                        r = int_sqrt(acc);
                        if (acc - r * r > r) r++;
                    end
                    if (r > 64'd2147483647) begin
                        r = 64'd2147483647;
                        rsp.status = mcve_pkg::ST_SAT;
                    end
                    if (r == 0) begin
                        rsp.status = mcve_pkg::ST_ZERO;
                    end else begin
                        for (int k = 0; k < rows_act; k++) begin
                            a = mat[k][i];
                            mag = (a < 0 ? -a : a) << FB;
                            uq = (mag + r / 2) / r;
                            mat[k][i] = clamp32(a < 0 ? -longint'(uq) : longint'(uq), sat);
                        end
                        rsp.result_value = r[31:0];
                    end
                end
            endcase
        end
        return rsp;
    endfunction

    // true when every row in use of column c was written
    function automatic bit column_ready(int c);
        for (int k = 0; k < rows_act; k++)
            if (!written[k][c]) return 0;
        return 1;
    endfunction

    // driver: one command offered per falling edge, held until transfer
    initial begin
        cmd_ch.valid = 0;
        cmd_ch.command = '0;
        cmd_ch.row_index = '0;
        cmd_ch.first_column = '0;
        cmd_ch.second_column = '0;
        cmd_ch.value = '0;
        rsp_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    // command handshake as seen at the rising edge
    always @(posedge i_clk) begin
        cmd_fire <= cmd_ch.valid && cmd_ch.ready;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!cmd_ch.valid || cmd_fire) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_item it;
                    it = pending_cmds.pop_front();
                    expected_rsps.push_back(engine_predict(it));
                    cmd_ch.valid <= 1;
                    cmd_ch.command <= it.command;
                    cmd_ch.row_index <= it.row_index;
                    cmd_ch.first_column <= it.first_column;
                    cmd_ch.second_column <= it.second_column;
                    cmd_ch.value <= it.value;
                end else begin
                    cmd_ch.valid <= 0;
                end
            end
            if (recv_hold) begin
                rsp_ch.ready <= 0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // long receiver stall, counted in cycles here
    initial begin
        wait (stall_go);
        @(negedge i_clk);
        recv_hold <= 1'b1;
        repeat (3000) @(negedge i_clk);
        recv_hold <= 1'b0;
    end

    // monitor: compare each response transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
                $error("response with nothing expected");
                errors++;
            end else begin
                t_resp e;
                e = expected_rsps.pop_front();
                if (rsp_ch.result_value !== e.result_value) begin
                    $error("result_value expected %0d actual %0d",
                           e.result_value, rsp_ch.result_value);
                    errors++;
                end
                if (rsp_ch.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, rsp_ch.status);
                    errors++;
                end
            end
        end
    end

    // watchdog
    longint cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_item mk(logic [2:0] c, int r, int i, int j, logic [31:0] v);
        t_item it;
        it.command = c;
        it.row_index = 4'(r);
        it.first_column = 4'(i);
        it.second_column = 4'(j);
        it.value = v;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || cmd_ch.valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // register write at the falling edge; ready is held high by the block
    task automatic write_reg(logic [mcve_pkg::CFG_IDX_W-1:0] idx, logic [4:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
        if (idx == mcve_pkg::CFG_ROWS)
            rows_act = (d == 0) ? 1 : (d > NR ? NR : d);
        else
            cols_act = (d == 0) ? 1 : (d > NC ? NC : d);
    endtask

    // fill the active block with small values so column commands see written data
    task automatic fill_block(int mag);
        for (int r = 0; r < rows_act; r++)
            for (int c = 0; c < cols_act; c++)
                pending_cmds.push_back(mk(mcve_pkg::CMD_WRITE, r, c, 0,
                    $urandom_range(2 * mag) - mag));
    endtask

    // random command that touches only written entries
    function automatic t_item random_cmd();
        t_item it;
        int r, i, j;
        logic [2:0] c;
        int sel = $urandom_range(99);
        r = $urandom_range(15);
        i = $urandom_range(15);
        j = $urandom_range(15);
        if (sel < 80) begin
            // mostly in range
            r = $urandom_range(rows_act - 1);
            i = $urandom_range(cols_act - 1);
            j = $urandom_range(cols_act - 1);
        end
        c = (sel < 3) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        if (c == mcve_pkg::CMD_READ && r < rows_act && i < cols_act && !written[r][i])
            c = mcve_pkg::CMD_WRITE;
        if ((c == mcve_pkg::CMD_SUB || c == mcve_pkg::CMD_DOT || c == mcve_pkg::CMD_NORM) &&
            i < cols_act &&
            (!column_ready(i) ||
             ((c != mcve_pkg::CMD_NORM) && j < cols_act && !column_ready(j))))
            c = mcve_pkg::CMD_WRITE;
        it = mk(c, r, i, j, $urandom());
        if (c == mcve_pkg::CMD_SUB) begin
            case ($urandom_range(3))
                0: it.value = 0;
                1: it.value = $urandom_range(262143) - 131072;
                default: ;
            endcase
        end else if (c == mcve_pkg::CMD_WRITE && $urandom_range(1)) begin
            it.value = $urandom_range(1 << 20) - (1 << 19);
        end
        return it;
    endfunction

    // random commands are queued one at a time so the predictor sees up-to-date state
    task automatic run_random(int n);
        for (int k = 0; k < n; k++) begin
            while (pending_cmds.size() > 2) @(posedge i_clk);
            pending_cmds.push_back(random_cmd());
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, every command and each special case
        write_reg(mcve_pkg::CFG_ROWS, 5'd4);
        write_reg(mcve_pkg::CFG_COLS, 5'd4);
        pending_cmds.push_back(mk(mcve_pkg::CMD_WRITE, 0, 0, 0, 32'h7fffffff));
        pending_cmds.push_back(mk(mcve_pkg::CMD_WRITE, 1, 0, 0, 32'h80000000));
        pending_cmds.push_back(mk(mcve_pkg::CMD_WRITE, 2, 0, 0, 32'h00010000));
        pending_cmds.push_back(mk(mcve_pkg::CMD_WRITE, 3, 0, 0, 32'hffff0000));
        for (int r = 0; r < 4; r++) begin
            pending_cmds.push_back(mk(mcve_pkg::CMD_WRITE, r, 1, 0, 0));
            pending_cmds.push_back(mk(mcve_pkg::CMD_WRITE, r, 2, 0, 32'h00030000));
        end
        pending_cmds.push_back(mk(mcve_pkg::CMD_READ, 1, 0, 0, 0));
        pending_cmds.push_back(mk(mcve_pkg::CMD_DOT, 0, 0, 0, 0));          // saturates
        pending_cmds.push_back(mk(mcve_pkg::CMD_SUB, 0, 0, 2, 0));          // zero scale
        pending_cmds.push_back(mk(mcve_pkg::CMD_SUB, 0, 0, 2, 32'h7fffffff)); // saturates
        pending_cmds.push_back(mk(mcve_pkg::CMD_NORM, 0, 1, 0, 0));         // zero norm
        pending_cmds.push_back(mk(mcve_pkg::CMD_NORM, 0, 0, 0, 0));         // saturated norm
        pending_cmds.push_back(mk(mcve_pkg::CMD_NORM, 0, 2, 0, 0));
        pending_cmds.push_back(mk(mcve_pkg::CMD_READ, 15, 0, 0, 0));        // row out of range
        pending_cmds.push_back(mk(mcve_pkg::CMD_DOT, 0, 0, 15, 0));         // column out of range
        pending_cmds.push_back(mk(3'd7, 0, 0, 0, 0));                       // unknown command
        pending_cmds.push_back(mk(mcve_pkg::CMD_READ, 2, 2, 0, 0));
        wait_drained();

        // phase 1: sender idles rarely, receiver often; long receiver stall once
        send_idle_pct = 17;
        recv_idle_pct = 55;
        write_reg(mcve_pkg::CFG_ROWS, 5'd3);
        write_reg(mcve_pkg::CFG_COLS, 5'd16);
        fill_block(1 << 18);
        stall_go = 1;
        run_random(250);

        // phase 2: roles swapped, out-of-range register writes clamp
        send_idle_pct = 55;
        recv_idle_pct = 17;
        write_reg(mcve_pkg::CFG_ROWS, 5'd0);
        write_reg(mcve_pkg::CFG_COLS, 5'd31);
        fill_block(1 << 20);
        run_random(250);

        // phase 3: no idling, all rows with two columns, then minimum columns
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(mcve_pkg::CFG_ROWS, 5'd16);
        write_reg(mcve_pkg::CFG_COLS, 5'd2);
        fill_block(1 << 17);
        run_random(150);
        write_reg(mcve_pkg::CFG_ROWS, 5'd2);
        write_reg(mcve_pkg::CFG_COLS, 5'd1);
        run_random(150);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
